/* hw/rtl/mcg_pkg.sv */
// Shared constants and types for the mipmap chain generator.
`timescale 1ns / 1ps
`default_nettype none
package mcg_pkg;

  localparam int unsigned MaxLog2Size  = 10;
  localparam int unsigned Channels     = 4;
  localparam int unsigned ChannelBits  = 16;
  localparam int unsigned ExpBits      = 4;
  localparam int unsigned CntBits      = MaxLog2Size;
  localparam int unsigned PosBits      = 9;
  localparam int unsigned HsumBits     = ChannelBits + 1;
  localparam int unsigned VsumBits     = ChannelBits + 2;
  localparam int unsigned LineDepth    = 1 << MaxLog2Size;
  localparam int unsigned LineAddrBits = MaxLog2Size;
  localparam int unsigned LineBits     = Channels * VsumBits;
  localparam int unsigned NumLevelRegs = MaxLog2Size + 1;

  localparam logic CfgLog2Width  = 1'b0;
  localparam logic CfgLog2Height = 1'b1;

  typedef logic [Channels-1:0][ChannelBits-1:0] texel_t;
  typedef logic [Channels-1:0][HsumBits-1:0]    hsum_t;

  typedef enum logic [1:0] {
    StIdle,
    StCalc,
    StAcc
  } seq_state_e;

  typedef struct packed {
    logic                    we;
    logic                    re;
    logic [LineAddrBits-1:0] addr;
    logic [LineBits-1:0]     wdata;
  } line_req_t;

endpackage
`default_nettype wire

/* hw/rtl/mcg_line_ram.sv */
// Line store of horizontal pair sums awaiting the vertical add, one word per level column pair.
`timescale 1ns / 1ps
`default_nettype none
module mcg_line_ram import mcg_pkg::*; (
  input  wire logic                clk_i,
  input  wire line_req_t           req_i,
  output      logic [LineBits-1:0] rdata_o
);

  logic [LineBits-1:0] mem [LineDepth];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_o <= mem[req_i.addr];
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/mipmap_chain_generator_core.sv */
// Top level of the mipmap chain generator: level sequencer and output register.
//
// Base texels enter on the texel channel (valid/ready) in raster order. For each
// word the sequencer walks the mip levels one at a time, from level 1 upward,
// and stops at the first level whose 2x2 block is not yet complete. Each
// completed block leaves as one word on the mip channel with its level and
// position; run_last marks the final word caused by one input texel.
// A level step has a calc state (counter update and line store read), then an
// accumulate state (the vertical add and rounding). An input costs an accept
// step, a calc and an accumulate step per emitted level and a calc step for the
// first level that completes no block, unless the top level was reached. A new
// texel is taken only once the sequencer is back in idle, since it handles one
// level at a time.
// The output register lets a new texel be taken while a word waits; a stalled
// receiver holds the sequencer in its accumulate step until the word is taken.
// Reset clears all level counters and sets both exponents to 10; the line
// store needs no clearing since every entry is written before it is read.
// A configuration write restarts the image and drops any partial image.
`timescale 1ns / 1ps
`default_nettype none
module mipmap_chain_generator_core import mcg_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic                   cfg_idx_i,
  input  wire logic [ExpBits-1:0]     cfg_wdata_i,
  input  wire logic                   texel_valid_i,
  output      logic                   texel_ready_o,
  input  wire logic [ChannelBits-1:0] texel_c0_i,
  input  wire logic [ChannelBits-1:0] texel_c1_i,
  input  wire logic [ChannelBits-1:0] texel_c2_i,
  input  wire logic [ChannelBits-1:0] texel_c3_i,
  output      logic                   mip_valid_o,
  input  wire logic                   mip_ready_i,
  output      logic [ExpBits-1:0]     mip_level_o,
  output      logic [PosBits-1:0]     pos_x_o,
  output      logic [PosBits-1:0]     pos_y_o,
  output      logic [ChannelBits-1:0] out_c0_o,
  output      logic [ChannelBits-1:0] out_c1_o,
  output      logic [ChannelBits-1:0] out_c2_o,
  output      logic [ChannelBits-1:0] out_c3_o,
  output      logic                   run_last_o
);

  seq_state_e state_q, state_d;
  logic [ExpBits-1:0] ew_q, eh_q;
  logic [ExpBits-1:0] ewc, ehc, levels;
  logic [CntBits-1:0] col_q [NumLevelRegs];
  logic [CntBits-1:0] row_q [NumLevelRegs];
  texel_t             pend_q [MaxLog2Size];
  texel_t             cur_q;
  hsum_t              hsum_q;
  logic [ExpBits-1:0] lvl_q;
  logic               hone_q, last_q;
  logic [PosBits-1:0] px_q, py_q;

  logic               out_valid_q, out_last_q;
  logic [ExpBits-1:0] out_lvl_q;
  logic [PosBits-1:0] out_px_q, out_py_q;
  texel_t             out_val_q;

  line_req_t           line_req;
  logic [LineBits-1:0] line_rdata;

  // Level geometry for the current level and the one below it.
  logic [ExpBits-1:0]      nxt_lvl, we, he, nwe, nhe;
  logic [CntBits-1:0]      xmask, ymask, nxmask, nymask, x, y, nx, ny;
  logic                    wone, hone, xlast, ylast, nemit, stop_h, stop_v;
  hsum_t                   hsum;
  logic [LineAddrBits-1:0] base;
  texel_t                  res;
  logic                    out_free, in_acc;

  assign ewc    = (ew_q > ExpBits'(MaxLog2Size)) ? ExpBits'(MaxLog2Size) : ew_q;
  assign ehc    = (eh_q > ExpBits'(MaxLog2Size)) ? ExpBits'(MaxLog2Size) : eh_q;
  assign levels = (ewc > ehc) ? ewc : ehc;

  assign nxt_lvl = lvl_q + ExpBits'(1);
  assign we      = (ewc > lvl_q) ? ewc - lvl_q : '0;
  assign he      = (ehc > lvl_q) ? ehc - lvl_q : '0;
  assign nwe     = (ewc > nxt_lvl) ? ewc - nxt_lvl : '0;
  assign nhe     = (ehc > nxt_lvl) ? ehc - nxt_lvl : '0;
  assign xmask   = ~({CntBits{1'b1}} << we);
  assign ymask   = ~({CntBits{1'b1}} << he);
  assign nxmask  = ~({CntBits{1'b1}} << nwe);
  assign nymask  = ~({CntBits{1'b1}} << nhe);
  assign x       = col_q[lvl_q] & xmask;
  assign y       = row_q[lvl_q] & ymask;
  assign nx      = col_q[nxt_lvl] & nxmask;
  assign ny      = row_q[nxt_lvl] & nymask;
  assign wone    = (we == '0);
  assign hone    = (he == '0);
  assign xlast   = (x == xmask);
  assign ylast   = (y == ymask);
  assign stop_h  = !wone && !x[0];
  assign stop_v  = !hone && !y[0];
  // The level below emits only if its own pair is complete in both directions.
  assign nemit   = (nxt_lvl < levels) && ((nwe == '0) || nx[0]) && ((nhe == '0) || ny[0]);
  assign base    = LineAddrBits'({LineAddrBits{1'b1}} ^ ({LineAddrBits{1'b1}} >> lvl_q));

  always_comb begin
    for (int c = 0; c < Channels; c++) begin
      hsum[c] = wone ? {cur_q[c], 1'b0}
                     : HsumBits'(pend_q[lvl_q[3:0] < ExpBits'(MaxLog2Size) ? lvl_q : '0][c])
                       + HsumBits'(cur_q[c]);
    end
  end

  always_comb begin
    logic [VsumBits-1:0] vt;
    vt = '0;
    for (int c = 0; c < Channels; c++) begin
      vt = hone_q ? {hsum_q[c], 1'b0}
                  : VsumBits'(hsum_q[c]) + line_rdata[c*VsumBits +: VsumBits];
      res[c] = ChannelBits'((vt + VsumBits'(2)) >> 2);
    end
  end

  assign out_free = !out_valid_q || mip_ready_i;
  assign in_acc   = texel_valid_i && texel_ready_o;

  // Next state. After a word the level below is visited whenever it exists, so that its
  // counters and pair or line entry are updated even when it emits nothing.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (in_acc && levels != '0) state_d = StCalc;
      StCalc: if (stop_h || stop_v) state_d = StIdle;
              else state_d = StAcc;
      StAcc:  if (out_free) state_d = (nxt_lvl < levels) ? StCalc : StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    texel_ready_o = 1'b0;
    line_req      = '0;
    case (state_q)
      StIdle: texel_ready_o = 1'b1;
      StCalc: begin
        line_req.addr = base + LineAddrBits'(x[CntBits-1:1]);
        if (!stop_h && stop_v) begin
          line_req.we = 1'b1;
          for (int c = 0; c < Channels; c++) begin
            line_req.wdata[c*VsumBits +: VsumBits] = VsumBits'(hsum[c]);
          end
        end
        line_req.re = !stop_h && !stop_v && !hone;
      end
      default: ;
    endcase
  end

  mcg_line_ram u_line (
    .clk_i,
    .req_i   (line_req),
    .rdata_o (line_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ew_q        <= ExpBits'(MaxLog2Size);
      eh_q        <= ExpBits'(MaxLog2Size);
      out_valid_q <= 1'b0;
      for (int l = 0; l < NumLevelRegs; l++) begin
        col_q[l] <= '0;
        row_q[l] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgLog2Width) ew_q <= cfg_wdata_i;
        else                           eh_q <= cfg_wdata_i;
        for (int l = 0; l < NumLevelRegs; l++) begin
          col_q[l] <= '0;
          row_q[l] <= '0;
        end
      end else if (state_q == StCalc) begin
        col_q[lvl_q] <= xlast ? '0 : x + CntBits'(1);
        row_q[lvl_q] <= xlast ? (ylast ? '0 : y + CntBits'(1)) : y;
      end
      if (state_q == StAcc && out_free) out_valid_q <= 1'b1;
      else if (mip_ready_i)             out_valid_q <= 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        cur_q <= {texel_c3_i, texel_c2_i, texel_c1_i, texel_c0_i};
        lvl_q <= '0;
      end
      StCalc: begin
        if (stop_h) pend_q[lvl_q] <= cur_q;
        hsum_q <= hsum;
        hone_q <= hone;
        px_q   <= PosBits'(x[CntBits-1:1]);
        py_q   <= PosBits'(y[CntBits-1:1]);
        last_q <= !nemit;
      end
      StAcc: begin
        if (out_free) begin
          cur_q      <= res;
          lvl_q      <= nxt_lvl;
          out_lvl_q  <= nxt_lvl;
          out_px_q   <= px_q;
          out_py_q   <= py_q;
          out_val_q  <= res;
          out_last_q <= last_q;
        end
      end
      default: ;
    endcase
  end

  assign mip_valid_o = out_valid_q;
  assign mip_level_o = out_lvl_q;
  assign pos_x_o     = out_px_q;
  assign pos_y_o     = out_py_q;
  assign out_c0_o    = out_val_q[0];
  assign out_c1_o    = out_val_q[1];
  assign out_c2_o    = out_val_q[2];
  assign out_c3_o    = out_val_q[3];
  assign run_last_o  = out_last_q;

endmodule
`default_nettype wire
